// ----- rtl/register_machine_alu_executor_macros.svh -----
// assertion macros for the register machine executor
`ifndef REGISTER_MACHINE_ALU_EXECUTOR_MACROS_SVH
`define REGISTER_MACHINE_ALU_EXECUTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMAE_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RMAE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/rmae_pkg.sv -----
// types, constants and helpers shared by the register machine executor
`timescale 1ns / 1ps
`default_nettype none

package rmae_pkg;

   localparam int NUM_REGS   = 32;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = 5;
   localparam int REG_AW     = $clog2(NUM_REGS);
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [IDX_W-1:0]             idx_type;

   typedef enum logic [3:0] {
      OP_IN   = 4'd0,
      OP_OUT  = 4'd1,
      OP_MOV  = 4'd2,
      OP_XCHG = 4'd3,
      OP_ADD  = 4'd4,
      OP_SUB  = 4'd5,
      OP_MUL  = 4'd6,
      OP_DIV  = 4'd7,
      OP_MOD  = 4'd8,
      OP_AND  = 4'd9,
      OP_OR   = 4'd10,
      OP_XOR  = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_XCHG,
      ST_ITER,
      ST_WRITE
   } state_type;

   typedef struct packed {
      op_type             mode;
      idx_type            dest_reg;
      idx_type            src_a;
      idx_type            src_b;
      logic               three_operand;
      logic signed [31:0] immediate;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic               div_error;
   } rsp_payload_type;

   // register index names an existing register
   function automatic logic idx_ok(idx_type idx);
      return {1'b0, idx} < (IDX_W + 1)'(NUM_REGS);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/register_machine_alu_executor.sv -----
// register machine executor: register file memory, execute control and iterative mul/div
`timescale 1ns / 1ps
`default_nettype none
`include "register_machine_alu_executor_macros.svh"

// Executes one decoded instruction per req beat against a file of NUM_REGS signed
// registers of DATA_WIDTH bits, all zero after reset. The register file is a memory
// with two registered read ports and one write port; per-register valid bits make an
// entry read as zero until it is first written, so no clearing pass runs after reset.
// One instruction is in flight at a time: req_stall is high from the accepting edge
// until the last register write, which also keeps every read from seeing a stale entry.
// IN, OUT, MOV, ADD, SUB, AND, OR, XOR and a divide by zero accept, then execute; XCHG
// makes two writes through the single write port; MUL, DIV and MOD run through the
// shift-add multiplier and restoring divider, which retire one bit per cycle.
// Results (OUT, divide error) land in an output register, so the next instruction is
// taken while a result beat still waits on rsp_stall; an instruction that needs that
// register while it is still held waits in execute. Unused modes retire silently.
module register_machine_alu_executor (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire rmae_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output rmae_pkg::rsp_payload_type rsp_payload
);
   import rmae_pkg::*;

   // control state
   state_type state_ff, state_in;

   // register file and per-entry valid bits
   data_type  reg_mem [NUM_REGS];
   logic      reg_valid_ff [NUM_REGS];

   // instruction fields held for the whole execution
   op_type    op_ff;
   idx_type   dest_ff;
   idx_type   srca_ff;
   data_type  imm_ff;

   // registered read data and its qualifiers
   data_type  rd_x_ff, rd_y_ff;
   logic      x_ok_ff, y_ok_ff;

   // iterative multiply / divide unit
   data_type          op_a_ff, op_b_ff, acc_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              neg_ff;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // combinational controls
   logic            accept;
   logic            arith_sel;
   idx_type         rd_idx_x, rd_idx_y;
   data_type        x_val, y_val, alu_val, final_val, mag_x, mag_y;
   data_type        shifted, trial;
   logic            slot_free;
   logic            wr_req, wr_en;
   idx_type         wr_idx;
   logic [REG_AW-1:0] wr_addr;
   data_type        wr_data;
   logic            rsp_load;
   rsp_payload_type rsp_data;
   logic            iter_start, iter_step;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // operand selection at accept: three-operand arithmetic reads a and b,
   // everything else reads dest and a
   always_comb begin
      arith_sel = 1'b0;
      case (req_payload.mode)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR: begin
            arith_sel = req_payload.three_operand;
         end
         default: begin
            arith_sel = 1'b0;
         end
      endcase
      rd_idx_x = arith_sel ? req_payload.src_a : req_payload.dest_reg;
      rd_idx_y = arith_sel ? req_payload.src_b : req_payload.src_a;
   end

   // register file: two reads on the accepting edge, one write per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_x_ff <= reg_mem[rd_idx_x[REG_AW-1:0]];
         rd_y_ff <= reg_mem[rd_idx_y[REG_AW-1:0]];
      end
   end

   // valid bits: unwritten or missing registers read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            reg_valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         reg_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // capture instruction fields and read qualifiers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_payload.mode;
         dest_ff <= req_payload.dest_reg;
         srca_ff <= req_payload.src_a;
         imm_ff  <= DATA_WIDTH'(req_payload.immediate);
         x_ok_ff <= idx_ok(rd_idx_x) && reg_valid_ff[rd_idx_x[REG_AW-1:0]];
         y_ok_ff <= idx_ok(rd_idx_y) && reg_valid_ff[rd_idx_y[REG_AW-1:0]];
      end
   end

   assign x_val = x_ok_ff ? rd_x_ff : '0;
   assign y_val = y_ok_ff ? rd_y_ff : '0;
   assign mag_x = x_val[DATA_WIDTH-1] ? -x_val : x_val;
   assign mag_y = y_val[DATA_WIDTH-1] ? -y_val : y_val;

   // combinational add, sub, and, or and xor
   always_comb begin
      case (op_ff)
         OP_ADD:  alu_val = x_val + y_val;
         OP_SUB:  alu_val = x_val - y_val;
         OP_AND:  alu_val = x_val & y_val;
         OP_OR:   alu_val = x_val | y_val;
         default: alu_val = x_val ^ y_val;
      endcase
   end

   // restoring divide step: remainder stays below the divisor magnitude
   assign shifted = {acc_ff[DATA_WIDTH-2:0], op_a_ff[DATA_WIDTH-1]};
   assign trial   = shifted - op_b_ff;

   // final value of the iterative unit, sign fixed for div and mod
   always_comb begin
      case (op_ff)
         OP_DIV:  final_val = neg_ff ? -op_a_ff : op_a_ff;
         OP_MOD:  final_val = neg_ff ? -acc_ff : acc_ff;
         default: final_val = acc_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_OUT: begin
                  if (slot_free) state_in = ST_IDLE;
               end
               OP_XCHG: begin
                  state_in = ST_XCHG;
               end
               OP_MUL: begin
                  state_in = ST_ITER;
               end
               OP_DIV, OP_MOD: begin
                  if (y_val != '0) state_in = ST_ITER;
                  else if (slot_free) state_in = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_XCHG: begin
            state_in = ST_IDLE;
         end
         ST_ITER: begin
            if (cnt_ff == '0) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the control
   always_comb begin
      req_stall  = 1'b1;
      wr_req     = 1'b0;
      wr_idx     = dest_ff;
      wr_data    = alu_val;
      rsp_load   = 1'b0;
      rsp_data   = '{out_value: 32'(x_val), div_error: 1'b0};
      iter_start = 1'b0;
      iter_step  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_IN: begin
                  wr_req  = 1'b1;
                  wr_data = imm_ff;
               end
               OP_OUT: begin
                  rsp_load = slot_free;
               end
               OP_MOV, OP_XCHG: begin
                  wr_req  = 1'b1;
                  wr_data = y_val;
               end
               OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
                  wr_req = 1'b1;
               end
               OP_MUL: begin
                  iter_start = 1'b1;
               end
               OP_DIV, OP_MOD: begin
                  if (y_val != '0) begin
                     iter_start = 1'b1;
                  end else begin
                     // zero divisor: error beat, destination untouched
                     rsp_load = slot_free;
                     rsp_data = '{out_value: '0, div_error: 1'b1};
                  end
               end
               default: begin
                  wr_req = 1'b0;
               end
            endcase
         end
         ST_XCHG: begin
            // second half of the swap: old dest value into src_a
            wr_req  = 1'b1;
            wr_idx  = srca_ff;
            wr_data = x_val;
         end
         ST_ITER: begin
            iter_step = 1'b1;
         end
         ST_WRITE: begin
            wr_req  = 1'b1;
            wr_data = final_val;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // writes to missing registers are dropped
   assign wr_en   = wr_req && idx_ok(wr_idx);
   assign wr_addr = wr_idx[REG_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // shift-add multiplier and restoring divider, one bit per cycle
   always_ff @(posedge clock) begin
      if (iter_start) begin
         acc_ff <= '0;
         cnt_ff <= CNT_W'(DATA_WIDTH - 1);
         if (op_ff == OP_MUL) begin
            op_a_ff <= x_val;
            op_b_ff <= y_val;
         end else begin
            op_a_ff <= mag_x;
            op_b_ff <= mag_y;
         end
         if (op_ff == OP_DIV) begin
            neg_ff <= x_val[DATA_WIDTH-1] ^ y_val[DATA_WIDTH-1];
         end else begin
            neg_ff <= x_val[DATA_WIDTH-1];
         end
      end else if (iter_step) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (op_ff == OP_MUL) begin
            if (op_b_ff[0]) acc_ff <= acc_ff + op_a_ff;
            op_a_ff <= op_a_ff << 1;
            op_b_ff <= op_b_ff >> 1;
         end else if ($unsigned(shifted) >= $unsigned(op_b_ff)) begin
            acc_ff  <= trial;
            op_a_ff <= {op_a_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            acc_ff  <= shifted;
            op_a_ff <= {op_a_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end
   end

   // output register between the execute logic and the rsp channel
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // an accepted instruction always goes to execute next
   `RMAE_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC,
      "accepted instruction did not reach execute")
   // a result beat never overwrites one that is still held
   `RMAE_ASSERT_NOW(a_rsp_no_overwrite, clock, reset, rsp_load,
      !rsp_valid_ff || !rsp_stall, "result register overwritten while held")
   // the iterative unit hands over to the write-back after its last bit
   `RMAE_ASSERT_NEXT(a_iter_done, clock, reset, state_ff == ST_ITER && cnt_ff == '0,
      state_ff == ST_WRITE, "iterative unit did not finish")
   // a written register reads as valid from then on
   `RMAE_ASSERT_NEXT(a_wr_valid, clock, reset, wr_en, reg_valid_ff[$past(wr_addr)],
      "valid bit not set by a write")
   // no register write while idle
   `RMAE_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !wr_req,
      "register write while idle")

endmodule

`default_nettype wire

// ----- tb/sv/register_machine_alu_executor_test.sv -----
// self-checking testbench for the register machine executor
`timescale 1ns / 1ps

module register_machine_alu_executor_test;
   import rmae_pkg::*;

   localparam int CLOCK_HALF_NS = 6;
   localparam int RUN_LIMIT_NS  = 10_000_000;
   localparam int DRAIN_CYCLES  = 50_000;
   localparam int SETTLE_CYCLES = 64;       // longer than the slowest mul/div
   localparam int REPORT_CAP    = 40;

   // modes outside the operation set, retired with no effect
   localparam logic [3:0] MODE_UNUSED_LO = 4'd12;
   localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] MINUS_ONE = -32'sd1;

   typedef logic [DATA_WIDTH-1:0] word_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   // shadow of the register file, updated at each accepted req beat
   word_type        reg_shadow [NUM_REGS];
   // expected rsp beats, oldest first
   rsp_payload_type pending_results [$];
   int              mismatch_count  = 0;

   // pacing controls shared by the test tasks
   bit              req_gaps_on     = 1'b1;
   bit              rsp_gaps_on     = 1'b1;
   int              holdoff_request = 0;

   register_machine_alu_executor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #(CLOCK_HALF_NS) clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow register file and instruction semantics
   // ---------------------------------------------------------------------

   // indexes past the last register read as zero
   function automatic word_type read_reg(idx_type idx);
      if (int'(idx) < NUM_REGS) return reg_shadow[idx];
      return '0;
   endfunction

   // writes past the last register are dropped
   function automatic void write_reg(idx_type idx, word_type value);
      if (int'(idx) < NUM_REGS) reg_shadow[idx] = value;
   endfunction

   // apply one instruction to the shadow and queue the beat it should cause
   function automatic void execute_instr(req_payload_type item);
      word_type        x;
      word_type        y;
      word_type        r;
      word_type        mx;
      word_type        my;
      word_type        q;
      logic            negate;
      rsp_payload_type res;
      res = '0;
      case (item.mode)
         OP_IN: begin
            write_reg(item.dest_reg, DATA_WIDTH'(item.immediate));
         end
         OP_OUT: begin
            // sign-extend from the register width, then take 32 bits
            res.out_value = 32'(signed'(read_reg(item.dest_reg)));
            pending_results.push_back(res);
         end
         OP_MOV: begin
            write_reg(item.dest_reg, read_reg(item.src_a));
         end
         OP_XCHG: begin
            x = read_reg(item.dest_reg);
            y = read_reg(item.src_a);
            write_reg(item.dest_reg, y);
            write_reg(item.src_a, x);
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR: begin
            x = item.three_operand ? read_reg(item.src_a) : read_reg(item.dest_reg);
            y = item.three_operand ? read_reg(item.src_b) : read_reg(item.src_a);
            if ((item.mode == OP_DIV || item.mode == OP_MOD) && y == '0) begin
               // zero divisor: error beat, destination left alone
               res.div_error = 1'b1;
               pending_results.push_back(res);
            end else begin
               case (item.mode)
                  OP_ADD:  r = x + y;
                  OP_SUB:  r = x - y;
                  OP_MUL:  r = x * y;
                  OP_AND:  r = x & y;
                  OP_OR:   r = x | y;
                  OP_XOR:  r = x ^ y;
                  default: begin
                     // truncating divide on magnitudes, sign fixed afterwards
                     mx = x[DATA_WIDTH-1] ? word_type'(0) - x : x;
                     my = y[DATA_WIDTH-1] ? word_type'(0) - y : y;
                     if (item.mode == OP_DIV) begin
                        q      = mx / my;
                        negate = x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1];
                     end else begin
                        q      = mx % my;
                        negate = x[DATA_WIDTH-1];
                     end
                     r = negate ? word_type'(0) - q : q;
                  end
               endcase
               write_reg(item.dest_reg, r);
            end
         end
         default: ;   // unused modes change nothing
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // checking and reporting
   // ---------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // every accepted rsp beat is matched against the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("rsp beat with nothing expected", 64'(rsp_payload), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.out_value !== want.out_value)
               report_mismatch("out_value", 64'(rsp_payload.out_value), 64'(want.out_value));
            if (rsp_payload.div_error !== want.div_error)
               report_mismatch("div_error", 64'(rsp_payload.div_error), 64'(want.div_error));
         end
      end
   end

   // ---------------------------------------------------------------------
   // pacing
   // ---------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // rsp side: random stall runs, plus a long hold-off when a test asks for one
   initial begin : rsp_pacing
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (holdoff_request > 0) begin
            hold_left       = holdoff_request;
            holdoff_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_gaps_on && $urandom_range(0, 3) == 0) stall_left = idle_length();
         end
      end
   end

   // offer one req beat and wait for it to be taken; valid stays high so a
   // following beat can go out back to back
   task automatic issue_instr(input req_payload_type item);
      int gap;
      gap = (req_gaps_on && $urandom_range(0, 9) < 3) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      execute_instr(item);
   endtask

   // stop offering and wait for every expected beat, with a cap
   task automatic wait_results_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // ---------------------------------------------------------------------
   // instruction builders
   // ---------------------------------------------------------------------

   function automatic req_payload_type instr(op_type op, idx_type d, idx_type a,
                                             idx_type b, logic three,
                                             logic signed [31:0] imm);
      req_payload_type it;
      it.mode          = op;
      it.dest_reg      = d;
      it.src_a         = a;
      it.src_b         = b;
      it.three_operand = three;
      it.immediate     = imm;
      return it;
   endfunction

   // bias toward a few low registers so instructions feed each other
   function automatic idx_type random_reg_index(int span);
      if ($urandom_range(0, 3) != 0) return idx_type'($urandom_range(0, span));
      return idx_type'($urandom_range(0, NUM_REGS - 1));
   endfunction

   // boundary values mixed with small and fully random ones
   function automatic logic signed [31:0] random_operand();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'sd1;
         2:       return MINUS_ONE;
         3:       return WORD_MIN;
         4:       return WORD_MAX;
         5:       return 32'($urandom_range(0, 40)) - 32'sd20;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_payload_type random_instr(int out_pct, int span);
      req_payload_type it;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < out_pct)
         it.mode = OP_OUT;
      else if (pick < out_pct + 18)
         it.mode = OP_IN;
      else if (pick < out_pct + 20)
         it.mode = op_type'(4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)));
      else
         it.mode = op_type'(4'($urandom_range(OP_MOV, OP_XOR)));
      it.dest_reg      = random_reg_index(span);
      it.src_a         = random_reg_index(span);
      it.src_b         = random_reg_index(span);
      it.three_operand = 1'($urandom_range(0, 1));
      it.immediate     = random_operand();
      return it;
   endfunction

   task automatic run_random(int count, int out_pct, int span);
      repeat (count) issue_instr(random_instr(out_pct, span));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // load the extremes; an untouched register reads zero
   task automatic test_load_and_output();
      issue_instr(instr(OP_IN,  1, 0, 0, 1'b0, WORD_MAX));
      issue_instr(instr(OP_IN,  2, 0, 0, 1'b1, WORD_MIN));
      issue_instr(instr(OP_IN,  3, 0, 0, 1'b0, MINUS_ONE));
      issue_instr(instr(OP_OUT, 0, 0, 0, 1'b0, '0));
      issue_instr(instr(OP_OUT, 2, 7, 9, 1'b1, '0));
   endtask

   // add, sub and mul wrap at the register width
   task automatic test_arith_wrap();
      issue_instr(instr(OP_ADD, 4, 1, 1, 1'b1, '0));   // max + max
      issue_instr(instr(OP_OUT, 4, 0, 0, 1'b0, '0));
      issue_instr(instr(OP_MUL, 6, 2, 3, 1'b1, '0));   // min * -1
      issue_instr(instr(OP_SUB, 6, 1, 0, 1'b0, '0));   // min - max, two-operand
      issue_instr(instr(OP_OUT, 6, 0, 0, 1'b0, '0));
   endtask

   task automatic test_logic_ops();
      issue_instr(instr(OP_AND, 7, 1, 3, 1'b1, '0));
      issue_instr(instr(OP_OR,  7, 2, 0, 1'b0, '0));
      issue_instr(instr(OP_XOR, 8, 7, 1, 1'b1, '0));
      issue_instr(instr(OP_OUT, 8, 0, 0, 1'b0, '0));
   endtask

   // min / -1 wraps, remainder follows the dividend, zero divisor errors
   task automatic test_divide_corners();
      issue_instr(instr(OP_DIV, 9,  2, 3, 1'b1, '0));
      issue_instr(instr(OP_OUT, 9,  0, 0, 1'b0, '0));
      issue_instr(instr(OP_MOD, 10, 2, 3, 1'b1, '0));
      issue_instr(instr(OP_OUT, 10, 0, 0, 1'b0, '0));
      issue_instr(instr(OP_DIV, 1,  0, 0, 1'b0, '0));  // r1 /= r0, r0 is zero
      issue_instr(instr(OP_MOD, 11, 3, 0, 1'b1, '0));
      issue_instr(instr(OP_MOD, 14, 2, 1, 1'b1, '0));  // min % max gives -1
      issue_instr(instr(OP_OUT, 14, 0, 0, 1'b0, '0));
      issue_instr(instr(OP_OUT, 1,  0, 0, 1'b0, '0));  // must still be max
   endtask

   // exchange swaps and ignores src_b and the operand form
   task automatic test_move_exchange();
      issue_instr(instr(OP_MOV,  15, 2, 5, 1'b1, '0));
      issue_instr(instr(OP_XCHG, 15, 3, 1, 1'b1, '0));
      issue_instr(instr(OP_OUT,  3,  0, 0, 1'b0, '0));
   endtask

   task automatic test_unused_modes();
      issue_instr(instr(op_type'(MODE_UNUSED_LO), 3, 3, 3, 1'b1, WORD_MAX));
      issue_instr(instr(op_type'(MODE_UNUSED_HI), 3, 1, 2, 1'b0, MINUS_ONE));
      issue_instr(instr(OP_OUT, 3, 0, 0, 1'b0, '0));
   endtask

   task automatic test_random_mix();
      run_random(600, 15, 7);
   endtask

   // rsp side holds off while req beats keep coming, then the sender waits
   // for every result before going on
   task automatic test_receiver_holdoff();
      req_gaps_on     = 1'b0;
      holdoff_request = 300;
      run_random(40, 50, 7);
      wait_results_drained();
      req_gaps_on     = 1'b1;
   endtask

   // tight register set: hazards between back-to-back instructions
   task automatic test_dependency_chains();
      run_random(130, 15, 2);
   endtask

   task automatic test_back_to_back();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      run_random(150, 15, 7);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   initial begin
      foreach (reg_shadow[i]) reg_shadow[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_load_and_output();
      test_arith_wrap();
      test_logic_ops();
      test_divide_corners();
      test_move_exchange();
      test_unused_modes();
      test_random_mix();
      test_receiver_holdoff();
      test_dependency_chains();
      test_back_to_back();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", 64'(pending_results.size()), '0);

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rmae_pkg.sv
rtl/register_machine_alu_executor.sv
tb/sv/register_machine_alu_executor_test.sv
